[hdl/lcdng_pkg.sv]
// Shared types, command codes and helper functions for the character-LCD nibble generator.
package lcdng_pkg;

   localparam int QueueDepthDefault = 2;

   localparam int StepW = 4;
   localparam logic [StepW-1:0] INIT_LAST_STEP = 4'd11;

   typedef enum logic [3:0] {
      OP_INIT        = 4'd0,
      OP_CLEAR       = 4'd1,
      OP_CURSOR_OFF  = 4'd2,
      OP_CURSOR_ON   = 4'd3,
      OP_DISPLAY_OFF = 4'd4,
      OP_DISPLAY_ON  = 4'd5,
      OP_GOTO        = 4'd6,
      OP_DATA        = 4'd7,
      OP_WRAP_START  = 4'd8,
      OP_WRAP_CHAR   = 4'd9,
      OP_GLYPH_ADDR  = 4'd10
   } op_type;

   typedef enum logic {
      CSR_LINE_COUNT     = 1'b0,
      CSR_CHARS_PER_LINE = 1'b1
   } csr_index_type;

   localparam logic RS_CMD = 1'b0;
   localparam logic RS_DAT = 1'b1;

   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
   localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
   localparam logic [7:0] CMD_CURSOR_ON  = 8'h0E;
   localparam logic [7:0] CMD_FUNC_1L    = 8'h20;
   localparam logic [7:0] CMD_FUNC_2L    = 8'h28;
   localparam logic [7:0] CMD_DDRAM      = 8'h80;
   localparam logic [1:0] CMD_CGRAM_TOP  = 2'b01;

   localparam logic [3:0] NIB_WAKE       = 4'h3;
   localparam logic [3:0] NIB_4BIT       = 4'h2;

   localparam logic [2:0] LINE_COUNT_RESET = 3'd2;
   localparam logic [5:0] CHARS_RESET      = 6'd16;

   typedef struct packed {
      logic       is_init;
      logic       two_line;
      logic [7:0] byte0;
      logic       rs0;
      logic       has_byte1;
      logic [7:0] byte1;
      logic       rs1;
   } job_type;

   // Set DDRAM address command for a column and line under the given line map.
   function automatic logic [7:0] addr_cmd(input logic [5:0] pos, input logic [1:0] ln,
                                           input logic [2:0] line_count);
      logic [7:0] addr;
      if (line_count == 3'd2) begin
         addr = {ln, 6'b0} + {2'b00, pos};
      end else if (line_count == 3'd4) begin
         addr = {1'b0, ln[1], 6'b0} + (ln[0] ? 8'd20 : 8'd0) + {2'b00, pos};
      end else begin
         addr = {2'b00, pos};
      end
      return CMD_DDRAM | {1'b0, addr[6:0]};
   endfunction

   function automatic logic [2:0] lines_in_use(input logic [2:0] line_count);
      if (line_count == 3'd2) return 3'd2;
      if (line_count == 3'd4) return 3'd4;
      return 3'd1;
   endfunction

   // Power-up sequence: three wake nibbles, switch to 4-bit, then four command bytes.
   function automatic logic [3:0] init_nibble(input logic [StepW-1:0] step,
                                              input logic two_line);
      logic [3:0] nib;
      case (step)
         4'd0, 4'd1, 4'd2: nib = NIB_WAKE;
         4'd3:             nib = NIB_4BIT;
         4'd4:             nib = CMD_FUNC_1L[7:4];
         4'd5:             nib = two_line ? CMD_FUNC_2L[3:0] : CMD_FUNC_1L[3:0];
         4'd6:             nib = CMD_ENTRY_MODE[7:4];
         4'd7:             nib = CMD_ENTRY_MODE[3:0];
         4'd8:             nib = CMD_DISP_ON[7:4];
         4'd9:             nib = CMD_DISP_ON[3:0];
         4'd10:            nib = CMD_CLEAR[7:4];
         4'd11:            nib = CMD_CLEAR[3:0];
         default:          nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

[hdl/char_lcd_nibble_command_generator.sv]
// Top level of the character-LCD nibble command generator.
// The first nibble of a transaction is registered in the job queue and then in the output register before it is valid.
// Throughput: one nibble per cycle from the sequencer while a job is queued and rsp_tready is high;
// a one-byte operation is two nibbles, a wrapped character with line break four and init twelve.
// A job queue of QUEUE_DEPTH entries separates decode from nibble output.
// Synchronous active-high reset: queue empty, line_count 2, chars_per_line 16, state zero.
module char_lcd_nibble_command_generator import lcdng_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // data_byte[7:0], position[13:8], line[15:14], blink[16]
   input  logic [3:0]  req_tuser,  // operation[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // nibble[3:0]
   output logic        rsp_tuser,  // register_select[0]
   output logic        rsp_tlast
);

   logic    push;
   job_type push_job;
   logic    pop;
   logic    queue_full;
   logic    head_valid;
   job_type head_job;

   lcdng_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   lcdng_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   lcdng_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hdl/lcdng_front.sv]
// Front end: config registers, operation decode, cursor and wrap tracking, job building.
module lcdng_front import lcdng_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [3:0]  req_tuser,
   input  logic        queue_full,
   output logic        push,
   output job_type     push_job
);

   logic [2:0] line_count_ff, line_count_in;
   logic [5:0] chars_ff, chars_in;
   logic       cursor_shown_ff, cursor_shown_in;
   logic       cursor_blink_ff, cursor_blink_in;
   logic [5:0] wrap_col_ff, wrap_col_in;
   logic [1:0] wrap_line_ff, wrap_line_in;

   op_type     op;
   logic [7:0] data_byte;
   logic [5:0] position;
   logic [1:0] line;
   logic       blink;
   logic       accept;
   logic       op_valid;
   logic [5:0] next_col;
   logic [2:0] next_line;
   logic [1:0] brk_line;

   assign op        = op_type'(req_tuser);
   assign data_byte = req_tdata[7:0];
   assign position  = req_tdata[13:8];
   assign line      = req_tdata[15:14];
   assign blink     = req_tdata[16];

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && op_valid;

   assign next_col  = wrap_col_ff + 6'd1;
   assign next_line = {1'b0, wrap_line_ff} + 3'd1;
   assign brk_line  = (next_line >= lines_in_use(line_count_ff)) ? 2'd0 : next_line[1:0];

   always_comb begin
      line_count_in = line_count_ff;
      chars_in      = chars_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_COUNT:     line_count_in = csr_wdata[2:0];
            CSR_CHARS_PER_LINE: chars_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cursor_shown_in = cursor_shown_ff;
      cursor_blink_in = cursor_blink_ff;
      wrap_col_in     = wrap_col_ff;
      wrap_line_in    = wrap_line_ff;
      op_valid        = 1'b1;
      push_job           = '0;
      push_job.two_line  = (line_count_ff == 3'd2);
      push_job.rs0       = RS_CMD;
      push_job.rs1       = RS_CMD;
      unique case (op)
         OP_INIT: begin
            push_job.is_init = 1'b1;
            cursor_shown_in  = 1'b0;
            cursor_blink_in  = 1'b0;
         end
         OP_CLEAR: push_job.byte0 = CMD_CLEAR;
         OP_CURSOR_OFF: begin
            push_job.byte0  = CMD_DISP_ON;
            cursor_shown_in = 1'b0;
            cursor_blink_in = 1'b0;
         end
         OP_CURSOR_ON: begin
            push_job.byte0  = CMD_CURSOR_ON | {7'b0, blink};
            cursor_shown_in = 1'b1;
            cursor_blink_in = blink;
         end
         OP_DISPLAY_OFF:
            push_job.byte0 = CMD_DISP_OFF | {6'b0, cursor_shown_ff, cursor_blink_ff};
         OP_DISPLAY_ON:
            push_job.byte0 = CMD_DISP_ON | {6'b0, cursor_shown_ff, cursor_blink_ff};
         OP_GOTO: push_job.byte0 = addr_cmd(position, line, line_count_ff);
         OP_DATA: begin
            push_job.byte0 = data_byte;
            push_job.rs0   = RS_DAT;
         end
         OP_WRAP_START: begin
            push_job.byte0 = addr_cmd(6'd0, 2'd0, line_count_ff);
            wrap_col_in    = 6'd0;
            wrap_line_in   = 2'd0;
         end
         OP_WRAP_CHAR: begin
            push_job.byte0 = data_byte;
            push_job.rs0   = RS_DAT;
            // a zero line length matches when the column wraps past 63
            if (next_col == chars_ff) begin
               push_job.has_byte1 = 1'b1;
               push_job.byte1     = addr_cmd(6'd0, brk_line, line_count_ff);
               wrap_col_in        = 6'd0;
               wrap_line_in       = brk_line;
            end else begin
               wrap_col_in = next_col;
            end
         end
         OP_GLYPH_ADDR: push_job.byte0 = {CMD_CGRAM_TOP, data_byte[2:0], 3'b000};
         default: op_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff   <= LINE_COUNT_RESET;
         chars_ff        <= CHARS_RESET;
         cursor_shown_ff <= 1'b0;
         cursor_blink_ff <= 1'b0;
         wrap_col_ff     <= 6'd0;
         wrap_line_ff    <= 2'd0;
      end else begin
         line_count_ff <= line_count_in;
         chars_ff      <= chars_in;
         if (accept) begin
            cursor_shown_ff <= cursor_shown_in;
            cursor_blink_ff <= cursor_blink_in;
            wrap_col_ff     <= wrap_col_in;
            wrap_line_ff    <= wrap_line_in;
         end
      end
   end

endmodule

[hdl/lcdng_queue.sv]
// Small job queue between the decoder and the nibble sequencer.
module lcdng_queue import lcdng_pkg::*; #(
   parameter int DEPTH = QueueDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

   job_type         mem_ff [DEPTH];
   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == DepthCnt);
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

[hdl/lcdng_back.sv]
// Back end: walks the head job nibble by nibble into the output register.
module lcdng_back import lcdng_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tuser,
   output logic       rsp_tlast
);

   logic [StepW-1:0] step_ff, step_in;
   logic             valid_ff, valid_in;
   logic [3:0]       nib_ff, nib_in;
   logic             rs_ff, rs_in;
   logic             last_ff, last_in;

   logic             load;
   logic             emit;
   logic             final_step;
   logic [7:0]       cur_byte;

   assign load = !valid_ff || rsp_tready;
   assign emit = load && head_valid;
   assign pop  = emit && final_step;

   always_comb begin
      cur_byte = step_ff[1] ? head_job.byte1 : head_job.byte0;
      if (head_job.is_init) begin
         nib_in     = init_nibble(step_ff, head_job.two_line);
         rs_in      = RS_CMD;
         final_step = (step_ff == INIT_LAST_STEP);
      end else begin
         nib_in     = step_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
         rs_in      = step_ff[1] ? head_job.rs1 : head_job.rs0;
         final_step = (step_ff == (head_job.has_byte1 ? 4'd3 : 4'd1));
      end
      last_in  = final_step;
      valid_in = load ? emit : valid_ff;
      step_in  = step_ff;
      if (emit) step_in = final_step ? '0 : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         nib_ff  <= nib_in;
         rs_ff   <= rs_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, nib_ff};
   assign rsp_tuser  = rs_ff;
   assign rsp_tlast  = last_ff;

   a_pop_needs_job : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("job retired from an empty queue");

   a_step_range : assert property (@(posedge clock) disable iff (reset)
      step_ff <= INIT_LAST_STEP) else $error("nibble step out of range");

   a_mid_job_held : assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0) |-> head_valid) else $error("job left the queue mid sequence");

endmodule
